// ----- sv/tpsq_pkg.sv -----
// shared types, codes and helpers of the two-phase slot command queue
package tpsq_pkg;

   localparam int QUEUE_CAPACITY_DEFAULT = 16;

   localparam int MODE_W = 3;
   localparam int SLOT_W = 4;
   localparam int GEN_W  = 16;
   localparam int LEN_W  = 16;
   localparam int SEQ_W  = 16;
   localparam int OCC_W  = 5;

   localparam logic [LEN_W-1:0] MAX_LEN_RESET = 16'd256;
   localparam logic [GEN_W-1:0] GEN_RESET     = 16'd1;

   localparam logic [MODE_W-1:0] MODE_RESERVE_WRITE = 3'd0;
   localparam logic [MODE_W-1:0] MODE_COMMIT_WRITE  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_RESERVE_READ  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_RELEASE_READ  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_CLEAR         = 3'd4;

   typedef enum logic [1:0] {
      SLOT_FREE    = 2'd0,
      SLOT_WRITING = 2'd1,
      SLOT_READY   = 2'd2,
      SLOT_READING = 2'd3
   } slot_state_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic check;
      logic step;
      logic finish;
   } tpsq_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic scan_needed;
      logic hit;
   } tpsq_status_type;

   // wrapping sequence order: a comes before b
   function automatic logic seq_before(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
      logic [SEQ_W-1:0] diff;
      diff = a - b;
      return diff[SEQ_W-1];
   endfunction

endpackage

// ----- sv/tpsq_ctrl.sv -----
// controller state machine: sequences check, slot scan and response
module tpsq_ctrl import tpsq_pkg::*; #(
   parameter int QUEUE_CAPACITY = QUEUE_CAPACITY_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   output logic            rsp_valid,
   output tpsq_cmd_type    cmd,
   input  tpsq_status_type status
);

   localparam int IW = (QUEUE_CAPACITY > 1) ? $clog2(QUEUE_CAPACITY) : 1;
   localparam logic [IW-1:0] LAST = IW'(QUEUE_CAPACITY - 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_CHECK,
      S_SCAN,
      S_RESP
   } ctrl_state_type;

   ctrl_state_type state_ff;
   logic [IW-1:0]  cnt_ff;
   logic           rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               cnt_ff   <= '0;
               state_ff <= status.scan_needed ? S_SCAN : S_RESP;
            end
            S_SCAN: begin
               // reserve write stops at the first free slot
               if (status.hit || cnt_ff == LAST) begin
                  state_ff <= S_RESP;
               end else begin
                  cnt_ff <= cnt_ff + IW'(1);
               end
            end
            S_RESP: begin
               state_ff     <= S_IDLE;
               rsp_valid_ff <= 1'b1;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign cmd.load   = (state_ff == S_IDLE) && start;
   assign cmd.check  = (state_ff == S_CHECK);
   assign cmd.step   = (state_ff == S_SCAN);
   assign cmd.finish = (state_ff == S_RESP);

   a_accept_to_check: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == S_CHECK)
      else $error("accepted command did not enter check");

   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !$past(rsp_valid_ff))
      else $error("response beat lasted more than one cycle");

endmodule

// ----- sv/tpsq_datapath.sv -----
// slot metadata arrays, queue registers and per-operation update logic
module tpsq_datapath import tpsq_pkg::*; #(
   parameter int QUEUE_CAPACITY = QUEUE_CAPACITY_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  tpsq_cmd_type       cmd,
   output tpsq_status_type    status,
   input  logic               csr_wr_en,
   input  logic [LEN_W-1:0]   csr_wr_data,
   input  logic [MODE_W-1:0]  req_mode,
   input  logic [SLOT_W-1:0]  req_slot_index,
   input  logic [GEN_W-1:0]   req_generation_token,
   input  logic               req_source,
   input  logic [LEN_W-1:0]   req_payload_length,
   output logic               rsp_ok,
   output logic [SLOT_W-1:0]  rsp_out_slot,
   output logic [GEN_W-1:0]   rsp_out_generation,
   output logic [LEN_W-1:0]   rsp_out_length,
   output logic               rsp_out_source,
   output logic [OCC_W-1:0]   rsp_occupied
);

   localparam int IW = (QUEUE_CAPACITY > 1) ? $clog2(QUEUE_CAPACITY) : 1;
   localparam int OW = $clog2(QUEUE_CAPACITY + 1);
   localparam logic [IW-1:0] LAST = IW'(QUEUE_CAPACITY - 1);
   localparam logic [OW-1:0] CAP  = OW'(QUEUE_CAPACITY);

   // slot metadata
   slot_state_type   slot_state_ff [QUEUE_CAPACITY];
   logic [GEN_W-1:0] slot_gen_ff   [QUEUE_CAPACITY];
   logic [SEQ_W-1:0] slot_seq_ff   [QUEUE_CAPACITY];
   logic [LEN_W-1:0] slot_len_ff   [QUEUE_CAPACITY];
   logic             slot_src_ff   [QUEUE_CAPACITY];

   // queue registers
   logic [LEN_W-1:0] max_len_ff;
   logic [GEN_W-1:0] cur_gen_ff, cur_gen_in;
   logic [SEQ_W-1:0] next_seq_ff, next_seq_in;
   logic [IW-1:0]    tail_ff, tail_in;
   logic [OW-1:0]    occ_ff, occ_in;

   // latched command beat
   logic [MODE_W-1:0] op_ff;
   logic [SLOT_W-1:0] idx_ff;
   logic [GEN_W-1:0]  token_ff;
   logic              src_ff;
   logic [LEN_W-1:0]  len_ff;

   // scan pointer and oldest-slot tracking
   logic [IW-1:0]    ptr_ff, ptr_in;
   logic             found_ff, found_in;
   logic [IW-1:0]    best_idx_ff, best_idx_in;
   logic [SEQ_W-1:0] best_seq_ff, best_seq_in;
   slot_state_type   best_state_ff, best_state_in;
   logic [GEN_W-1:0] best_gen_ff, best_gen_in;
   logic [LEN_W-1:0] best_len_ff, best_len_in;
   logic             best_src_ff, best_src_in;

   // result fields
   logic             res_ok_ff, res_ok_in;
   logic [IW-1:0]    res_slot_ff, res_slot_in;
   logic [GEN_W-1:0] res_gen_ff, res_gen_in;
   logic [LEN_W-1:0] res_len_ff, res_len_in;
   logic             res_src_ff, res_src_in;

   // array write port
   logic             st_we, gen_we, seq_we, len_we, src_we;
   logic [IW-1:0]    wa;
   slot_state_type   st_wd;
   logic [LEN_W-1:0] len_wd;

   // single read port
   logic [IW-1:0]    ra;
   slot_state_type   rd_state;
   logic [GEN_W-1:0] rd_gen;
   logic [SEQ_W-1:0] rd_seq;
   logic [LEN_W-1:0] rd_len;
   logic             rd_src;

   logic             idx_in_range;
   logic             wr_precheck;
   logic [IW-1:0]    ptr_next;

   assign idx_in_range = {{(32-SLOT_W){1'b0}}, idx_ff} < 32'(QUEUE_CAPACITY);
   assign wr_precheck  = (len_ff != '0) && (len_ff <= max_len_ff) && (occ_ff < CAP);
   assign ptr_next     = (ptr_ff == LAST) ? '0 : ptr_ff + IW'(1);

   assign ra       = cmd.check ? IW'(idx_ff) : ptr_ff;
   assign rd_state = slot_state_ff[ra];
   assign rd_gen   = slot_gen_ff[ra];
   assign rd_seq   = slot_seq_ff[ra];
   assign rd_len   = slot_len_ff[ra];
   assign rd_src   = slot_src_ff[ra];

   always_comb begin
      status.scan_needed = 1'b0;
      status.hit         = 1'b0;
      st_we  = 1'b0;
      gen_we = 1'b0;
      seq_we = 1'b0;
      len_we = 1'b0;
      src_we = 1'b0;
      wa     = ra;
      st_wd  = SLOT_FREE;
      len_wd = '0;

      cur_gen_in    = cur_gen_ff;
      next_seq_in   = next_seq_ff;
      tail_in       = tail_ff;
      occ_in        = occ_ff;
      ptr_in        = ptr_ff;
      found_in      = found_ff;
      best_idx_in   = best_idx_ff;
      best_seq_in   = best_seq_ff;
      best_state_in = best_state_ff;
      best_gen_in   = best_gen_ff;
      best_len_in   = best_len_ff;
      best_src_in   = best_src_ff;
      res_ok_in     = res_ok_ff;
      res_slot_in   = res_slot_ff;
      res_gen_in    = res_gen_ff;
      res_len_in    = res_len_ff;
      res_src_in    = res_src_ff;

      if (cmd.load) begin
         res_ok_in   = 1'b0;
         res_slot_in = '0;
         res_gen_in  = '0;
         res_len_in  = '0;
         res_src_in  = 1'b0;
      end

      if (cmd.check) begin
         case (op_ff)
            MODE_RESERVE_WRITE: begin
               status.scan_needed = wr_precheck;
               ptr_in = tail_ff;
            end
            MODE_COMMIT_WRITE: begin
               if (idx_in_range && rd_state == SLOT_WRITING && rd_gen == token_ff) begin
                  st_we  = 1'b1;
                  len_we = 1'b1;
                  if (token_ff == cur_gen_ff) begin
                     st_wd     = SLOT_READY;
                     len_wd    = len_ff;
                     src_we    = 1'b1;
                     res_ok_in = 1'b1;
                  end else begin
                     // cleared while being written
                     st_wd = SLOT_FREE;
                     if (occ_ff != '0) begin
                        occ_in = occ_ff - OW'(1);
                     end
                  end
               end
            end
            MODE_RESERVE_READ: begin
               status.scan_needed = (occ_ff != '0);
               ptr_in   = '0;
               found_in = 1'b0;
            end
            MODE_RELEASE_READ: begin
               if (idx_in_range && rd_state == SLOT_READING && rd_gen == token_ff) begin
                  st_we     = 1'b1;
                  st_wd     = SLOT_FREE;
                  len_we    = 1'b1;
                  res_ok_in = (token_ff == cur_gen_ff);
                  if (occ_ff != '0) begin
                     occ_in = occ_ff - OW'(1);
                  end
               end
            end
            MODE_CLEAR: begin
               status.scan_needed = 1'b1;
               cur_gen_in = (cur_gen_ff + GEN_W'(1) == '0) ? GEN_W'(1) : cur_gen_ff + GEN_W'(1);
               tail_in    = '0;
               occ_in     = '0;
               ptr_in     = '0;
            end
            default: begin
            end
         endcase
      end

      if (cmd.step) begin
         ptr_in = ptr_next;
         case (op_ff)
            MODE_RESERVE_WRITE: begin
               if (rd_state == SLOT_FREE) begin
                  status.hit  = 1'b1;
                  st_we       = 1'b1;
                  st_wd       = SLOT_WRITING;
                  gen_we      = 1'b1;
                  seq_we      = 1'b1;
                  len_we      = 1'b1;
                  next_seq_in = next_seq_ff + SEQ_W'(1);
                  tail_in     = ptr_next;
                  occ_in      = occ_ff + OW'(1);
                  res_ok_in   = 1'b1;
                  res_slot_in = ptr_ff;
                  res_gen_in  = cur_gen_ff;
               end
            end
            MODE_RESERVE_READ: begin
               if (rd_state != SLOT_FREE && (!found_ff || seq_before(rd_seq, best_seq_ff))) begin
                  found_in      = 1'b1;
                  best_idx_in   = ptr_ff;
                  best_seq_in   = rd_seq;
                  best_state_in = rd_state;
                  best_gen_in   = rd_gen;
                  best_len_in   = rd_len;
                  best_src_in   = rd_src;
               end
            end
            MODE_CLEAR: begin
               // in-flight slots survive and stay counted
               if (rd_state == SLOT_WRITING || rd_state == SLOT_READING) begin
                  occ_in = occ_ff + OW'(1);
               end else begin
                  st_we  = 1'b1;
                  st_wd  = SLOT_FREE;
                  len_we = 1'b1;
                  gen_we = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      if (cmd.finish && op_ff == MODE_RESERVE_READ && found_ff && best_state_ff == SLOT_READY) begin
         wa          = best_idx_ff;
         st_we       = 1'b1;
         st_wd       = SLOT_READING;
         res_ok_in   = 1'b1;
         res_slot_in = best_idx_ff;
         res_gen_in  = best_gen_ff;
         res_len_in  = best_len_ff;
         res_src_in  = best_src_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff  <= MAX_LEN_RESET;
         cur_gen_ff  <= GEN_RESET;
         next_seq_ff <= '0;
         tail_ff     <= '0;
         occ_ff      <= '0;
         for (int i = 0; i < QUEUE_CAPACITY; i++) begin
            slot_state_ff[i] <= SLOT_FREE;
         end
      end else begin
         if (csr_wr_en) begin
            max_len_ff <= csr_wr_data;
         end
         cur_gen_ff  <= cur_gen_in;
         next_seq_ff <= next_seq_in;
         tail_ff     <= tail_in;
         occ_ff      <= occ_in;
         if (st_we) begin
            slot_state_ff[wa] <= st_wd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (gen_we) begin
         slot_gen_ff[wa] <= cur_gen_ff;
      end
      if (seq_we) begin
         slot_seq_ff[wa] <= next_seq_ff;
      end
      if (len_we) begin
         slot_len_ff[wa] <= len_wd;
      end
      if (src_we) begin
         slot_src_ff[wa] <= src_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_mode;
         idx_ff   <= req_slot_index;
         token_ff <= req_generation_token;
         src_ff   <= req_source;
         len_ff   <= req_payload_length;
      end
      ptr_ff        <= ptr_in;
      found_ff      <= found_in;
      best_idx_ff   <= best_idx_in;
      best_seq_ff   <= best_seq_in;
      best_state_ff <= best_state_in;
      best_gen_ff   <= best_gen_in;
      best_len_ff   <= best_len_in;
      best_src_ff   <= best_src_in;
      res_ok_ff     <= res_ok_in;
      res_slot_ff   <= res_slot_in;
      res_gen_ff    <= res_gen_in;
      res_len_ff    <= res_len_in;
      res_src_ff    <= res_src_in;
   end

   assign rsp_ok             = res_ok_ff;
   assign rsp_out_slot       = SLOT_W'(res_slot_ff);
   assign rsp_out_generation = res_gen_ff;
   assign rsp_out_length     = res_len_ff;
   assign rsp_out_source     = res_src_ff;
   assign rsp_occupied       = OCC_W'(occ_ff);

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CAP)
      else $error("occupied count above capacity");

   a_reserved_slot_writing: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && res_ok_ff && op_ff == MODE_RESERVE_WRITE)
         |-> slot_state_ff[res_slot_ff] == SLOT_WRITING)
      else $error("reserved slot not marked writing");

   a_hit_only_in_scan: assert property (@(posedge clock) disable iff (reset)
      status.hit |-> cmd.step && op_ff == MODE_RESERVE_WRITE)
      else $error("free-slot hit outside reserve write scan");

endmodule

// ----- sv/two_phase_slot_command_queue.sv -----
// top level: metadata queue of reserve/commit slots, one command at a time
//
// A command is taken when start is high and busy is low; its single response
// appears on the rsp_ ports for one cycle with rsp_valid high and must be
// taken then, since the receiver cannot stall. Commit write, release read and
// unused modes skip the slot scan. Reserve write,
// reserve read and clear step through the slot table one slot per cycle on a
// single metadata read port: reserve write probes from the tail pointer up to
// the first free slot (1 to QUEUE_CAPACITY slots), and skips the scan when
// the length check or the full check fails; reserve read and clear probe all
// QUEUE_CAPACITY slots, reserve read none when the queue is empty. A new
// command can be accepted in the cycle of the response beat.
// max_payload_length is written through csr_wr_en and csr_wr_data; the user must
// write it only while the block is idle, and the block itself does not enforce this.
module two_phase_slot_command_queue import tpsq_pkg::*; #(
   parameter int QUEUE_CAPACITY = QUEUE_CAPACITY_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [LEN_W-1:0]  csr_wr_data,
   input  logic              start,
   output logic              busy,
   input  logic [MODE_W-1:0] req_mode,
   input  logic [SLOT_W-1:0] req_slot_index,
   input  logic [GEN_W-1:0]  req_generation_token,
   input  logic              req_source,
   input  logic [LEN_W-1:0]  req_payload_length,
   output logic              rsp_valid,
   output logic              rsp_ok,
   output logic [SLOT_W-1:0] rsp_out_slot,
   output logic [GEN_W-1:0]  rsp_out_generation,
   output logic [LEN_W-1:0]  rsp_out_length,
   output logic              rsp_out_source,
   output logic [OCC_W-1:0]  rsp_occupied
);

   tpsq_cmd_type    cmd;
   tpsq_status_type status;

   tpsq_ctrl #(
      .QUEUE_CAPACITY(QUEUE_CAPACITY)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   tpsq_datapath #(
      .QUEUE_CAPACITY(QUEUE_CAPACITY)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data),
      .req_mode             (req_mode),
      .req_slot_index       (req_slot_index),
      .req_generation_token (req_generation_token),
      .req_source           (req_source),
      .req_payload_length   (req_payload_length),
      .rsp_ok               (rsp_ok),
      .rsp_out_slot         (rsp_out_slot),
      .rsp_out_generation   (rsp_out_generation),
      .rsp_out_length       (rsp_out_length),
      .rsp_out_source       (rsp_out_source),
      .rsp_occupied         (rsp_occupied)
   );

endmodule

// ----- bench/slot_queue_scoreboard_pkg.sv -----
// scoreboard class: predicted slot queue state and the store of expected response beats
`timescale 1ns / 100ps
package slot_queue_scoreboard_pkg;
   import tpsq_pkg::*;

   typedef struct packed {
      logic              ok;
      logic [SLOT_W-1:0] slot;
      logic [GEN_W-1:0]  generation;
      logic [LEN_W-1:0]  length;
      logic              source;
      logic [OCC_W-1:0]  occupied;
   } slot_queue_response_type;

   class slot_queue_scoreboard;
      slot_state_type   state_of[QUEUE_CAPACITY_DEFAULT];
      logic [GEN_W-1:0] gen_of[QUEUE_CAPACITY_DEFAULT];
      logic [SEQ_W-1:0] seq_of[QUEUE_CAPACITY_DEFAULT];
      logic [LEN_W-1:0] len_of[QUEUE_CAPACITY_DEFAULT];
      logic             src_of[QUEUE_CAPACITY_DEFAULT];
      logic [GEN_W-1:0] cur_gen;
      logic [SEQ_W-1:0] next_seq;
      logic [LEN_W-1:0] max_len;
      int unsigned      tail;
      int unsigned      occ;
      int unsigned      mismatch_count;
      slot_queue_response_type expected_beats[$];

      function new();
         for (int i = 0; i < QUEUE_CAPACITY_DEFAULT; i++) begin
            state_of[i] = SLOT_FREE;
            gen_of[i]   = '0;
            seq_of[i]   = '0;
            len_of[i]   = '0;
            src_of[i]   = 1'b0;
         end
         cur_gen        = GEN_RESET;
         next_seq       = '0;
         max_len        = MAX_LEN_RESET;
         tail           = 0;
         occ            = 0;
         mismatch_count = 0;
      endfunction

      function void write_max_length(input logic [LEN_W-1:0] value);
         max_len = value;
      endfunction

      // wrapping order of sequence numbers
      function bit precedes(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
         logic [SEQ_W-1:0] d;
         d = a - b;
         return d >= 16'h8000;
      endfunction

      function slot_queue_response_type note_command(input logic [MODE_W-1:0] mode,
                                                     input logic [SLOT_W-1:0] idx,
                                                     input logic [GEN_W-1:0]  token,
                                                     input logic              src,
                                                     input logic [LEN_W-1:0]  len);
         slot_queue_response_type r;
         int unsigned c;
         int unsigned best;
         bit found;
         r = '0;
         found = 1'b0;
         best = 0;
         case (mode)
            MODE_RESERVE_WRITE: begin
               if (len != 0 && len <= max_len && occ < QUEUE_CAPACITY_DEFAULT) begin
                  c = (tail >= QUEUE_CAPACITY_DEFAULT) ? 0 : tail;
                  for (int i = 0; i < QUEUE_CAPACITY_DEFAULT; i++) begin
                     if (!found) begin
                        if (state_of[c] == SLOT_FREE) begin
                           found       = 1'b1;
                           state_of[c] = SLOT_WRITING;
                           gen_of[c]   = cur_gen;
                           seq_of[c]   = next_seq;
                           len_of[c]   = '0;
                           next_seq    = next_seq + 1'b1;
                           tail        = (c + 1 >= QUEUE_CAPACITY_DEFAULT) ? 0 : c + 1;
                           occ++;
                           r.ok         = 1'b1;
                           r.slot       = SLOT_W'(c);
                           r.generation = cur_gen;
                        end else begin
                           c = (c + 1 >= QUEUE_CAPACITY_DEFAULT) ? 0 : c + 1;
                        end
                     end
                  end
               end
            end
            MODE_COMMIT_WRITE: begin
               if (idx < QUEUE_CAPACITY_DEFAULT && state_of[idx] == SLOT_WRITING &&
                   gen_of[idx] == token) begin
                  if (token == cur_gen) begin
                     src_of[idx]   = src;
                     len_of[idx]   = len;
                     state_of[idx] = SLOT_READY;
                     r.ok = 1'b1;
                  end else begin
                     // cleared while being written
                     len_of[idx]   = '0;
                     state_of[idx] = SLOT_FREE;
                     if (occ > 0) occ--;
                  end
               end
            end
            MODE_RESERVE_READ: begin
               if (occ > 0) begin
                  for (int i = 0; i < QUEUE_CAPACITY_DEFAULT; i++) begin
                     if (state_of[i] != SLOT_FREE &&
                         (!found || precedes(seq_of[i], seq_of[best]))) begin
                        best  = i;
                        found = 1'b1;
                     end
                  end
                  if (found && state_of[best] == SLOT_READY) begin
                     state_of[best] = SLOT_READING;
                     r.ok         = 1'b1;
                     r.slot       = SLOT_W'(best);
                     r.generation = gen_of[best];
                     r.length     = len_of[best];
                     r.source     = src_of[best];
                  end
               end
            end
            MODE_RELEASE_READ: begin
               if (idx < QUEUE_CAPACITY_DEFAULT && state_of[idx] == SLOT_READING &&
                   gen_of[idx] == token) begin
                  r.ok          = (token == cur_gen);
                  state_of[idx] = SLOT_FREE;
                  len_of[idx]   = '0;
                  if (occ > 0) occ--;
               end
            end
            MODE_CLEAR: begin
               cur_gen = cur_gen + 1'b1;
               if (cur_gen == 0) cur_gen = 1;
               tail = 0;
               occ  = 0;
               // in-flight slots survive and stay counted
               for (int i = 0; i < QUEUE_CAPACITY_DEFAULT; i++) begin
                  if (state_of[i] == SLOT_WRITING || state_of[i] == SLOT_READING) begin
                     occ++;
                  end else begin
                     state_of[i] = SLOT_FREE;
                     len_of[i]   = '0;
                     gen_of[i]   = cur_gen;
                  end
               end
            end
            default: ;
         endcase
         r.occupied = OCC_W'(occ);
         expected_beats.push_back(r);
         return r;
      endfunction

      function void check_response(input slot_queue_response_type got);
         slot_queue_response_type want;
         if (expected_beats.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected beat: ok=%0d slot=%0d gen=%h len=%h src=%0d occ=%0d",
                        got.ok, got.slot, got.generation, got.length, got.source,
                        got.occupied);
         end else begin
            want = expected_beats.pop_front();
            if (got.ok !== want.ok || got.slot !== want.slot ||
                got.generation !== want.generation || got.length !== want.length ||
                got.source !== want.source || got.occupied !== want.occupied) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch expected ok=%0d slot=%0d gen=%h len=%h src=%0d occ=%0d",
                           want.ok, want.slot, want.generation, want.length, want.source,
                           want.occupied);
                  $display("         actual   ok=%0d slot=%0d gen=%h len=%h src=%0d occ=%0d",
                           got.ok, got.slot, got.generation, got.length, got.source,
                           got.occupied);
               end
            end
         end
      endfunction

      function int unsigned outstanding();
         return expected_beats.size();
      endfunction

      function bit failed();
         return mismatch_count != 0 || expected_beats.size() != 0;
      endfunction
   endclass

endpackage

// ----- bench/tb.sv -----
// top-level bench: drives commands and register writes into the slot queue and checks responses
`timescale 1ns / 100ps
module tb import tpsq_pkg::*, slot_queue_scoreboard_pkg::*;;

   localparam int unsigned IDLE_LIMIT = 2000;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic [GEN_W-1:0]  generation;
   } slot_ticket_type;

   logic              clock;
   logic              reset;
   logic              csr_wr_en;
   logic [LEN_W-1:0]  csr_wr_data;
   logic              start;
   logic              busy;
   logic [MODE_W-1:0] req_mode;
   logic [SLOT_W-1:0] req_slot_index;
   logic [GEN_W-1:0]  req_generation_token;
   logic              req_source;
   logic [LEN_W-1:0]  req_payload_length;
   logic              rsp_valid;
   logic              rsp_ok;
   logic [SLOT_W-1:0] rsp_out_slot;
   logic [GEN_W-1:0]  rsp_out_generation;
   logic [LEN_W-1:0]  rsp_out_length;
   logic              rsp_out_source;
   logic [OCC_W-1:0]  rsp_occupied;

   slot_queue_scoreboard queue_model;
   slot_ticket_type      writing_tickets[$];
   slot_ticket_type      reading_tickets[$];
   int unsigned          idle_cycles;

   two_phase_slot_command_queue i_dut (
      .clock                (clock),
      .reset                (reset),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data),
      .start                (start),
      .busy                 (busy),
      .req_mode             (req_mode),
      .req_slot_index       (req_slot_index),
      .req_generation_token (req_generation_token),
      .req_source           (req_source),
      .req_payload_length   (req_payload_length),
      .rsp_valid            (rsp_valid),
      .rsp_ok               (rsp_ok),
      .rsp_out_slot         (rsp_out_slot),
      .rsp_out_generation   (rsp_out_generation),
      .rsp_out_length       (rsp_out_length),
      .rsp_out_source       (rsp_out_source),
      .rsp_occupied         (rsp_occupied)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         queue_model.check_response(slot_queue_response_type'({rsp_ok, rsp_out_slot,
            rsp_out_generation, rsp_out_length, rsp_out_source, rsp_occupied}));
   end

   // watchdog on stretches with no beat on either side
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   function automatic int unsigned draw_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [LEN_W-1:0] draw_length();
      int unsigned r;
      r = $urandom_range(0, 9);
      case (r)
         0: return '0;
         1: return queue_model.max_len;
         2: return queue_model.max_len + 1'b1;
         3: return LEN_W'($urandom);
         default: return LEN_W'($urandom_range(1, queue_model.max_len));
      endcase
   endfunction

   task automatic issue(input logic [MODE_W-1:0] mode, input logic [SLOT_W-1:0] idx,
                        input logic [GEN_W-1:0] token, input logic src,
                        input logic [LEN_W-1:0] len, input int unsigned gap,
                        output slot_queue_response_type predicted);
      req_mode             <= mode;
      req_slot_index       <= idx;
      req_generation_token <= token;
      req_source           <= src;
      req_payload_length   <= len;
      start                <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = queue_model.note_command(mode, idx, token, src, len);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_for_idle();
      start <= 1'b0;
      while (queue_model.outstanding() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic program_max_length(input logic [LEN_W-1:0] value);
      wait_for_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      queue_model.write_max_length(value);
      csr_wr_en <= 1'b0;
   endtask

   task automatic keep_ticket(input logic [MODE_W-1:0] mode, input slot_queue_response_type p);
      if (p.ok && mode == MODE_RESERVE_WRITE)
         writing_tickets.push_back(slot_ticket_type'{p.slot, p.generation});
      if (p.ok && mode == MODE_RESERVE_READ)
         reading_tickets.push_back(slot_ticket_type'{p.slot, p.generation});
   endtask

   task automatic run_directed();
      slot_queue_response_type w0, r0, w1, w2, w3, r3, p;
      issue(MODE_RESERVE_READ, '0, '0, 1'b0, '0, draw_gap(), p);          // empty queue
      issue(MODE_RESERVE_WRITE, '0, '0, 1'b0, '0, draw_gap(), p);         // zero length
      issue(MODE_RESERVE_WRITE, '0, '0, 1'b0, 16'd257, draw_gap(), p);    // too long
      issue(MODE_RESERVE_WRITE, '0, '0, 1'b0, 16'd256, draw_gap(), w0);
      issue(MODE_COMMIT_WRITE, w0.slot, w0.generation ^ 16'h8000, 1'b1, 16'hFFFF, draw_gap(), p);
      issue(MODE_COMMIT_WRITE, w0.slot, w0.generation, 1'b1, 16'hFFFF, draw_gap(), p);
      issue(MODE_RESERVE_READ, '0, '0, 1'b0, '0, draw_gap(), r0);
      issue(MODE_RELEASE_READ, r0.slot, ~r0.generation, 1'b0, '0, draw_gap(), p);
      issue(MODE_RELEASE_READ, r0.slot, r0.generation, 1'b0, '0, draw_gap(), p);
      issue(MODE_RESERVE_WRITE, '0, '0, 1'b0, 16'd1, draw_gap(), w1);
      issue(MODE_RESERVE_WRITE, '0, '0, 1'b0, 16'd1, draw_gap(), w2);
      issue(MODE_COMMIT_WRITE, w2.slot, w2.generation, 1'b0, '0, draw_gap(), p);
      // oldest is still being written
      issue(MODE_RESERVE_READ, '0, '0, 1'b0, '0, draw_gap(), p);
      issue(MODE_CLEAR, '0, '0, 1'b0, '0, draw_gap(), p);
      // commit after clear frees the slot
      issue(MODE_COMMIT_WRITE, w1.slot, w1.generation, 1'b1, 16'h1234, draw_gap(), p);
      issue(MODE_RESERVE_WRITE, '0, '0, 1'b0, 16'd100, draw_gap(), w3);
      issue(MODE_COMMIT_WRITE, w3.slot, w3.generation, 1'b1, 16'h5555, draw_gap(), p);
      issue(MODE_RESERVE_READ, '0, '0, 1'b0, '0, draw_gap(), r3);
      issue(MODE_CLEAR, '0, '0, 1'b0, '0, draw_gap(), p);
      // release after clear frees but reports not ok
      issue(MODE_RELEASE_READ, r3.slot, r3.generation, 1'b0, '0, draw_gap(), p);
      issue(3'd5, '1, '1, 1'b1, '1, draw_gap(), p);
      issue(3'd6, '0, '0, 1'b0, '0, draw_gap(), p);
      issue(3'd7, '1, '1, 1'b1, '1, draw_gap(), p);
      issue(MODE_RESERVE_WRITE, '1, '1, 1'b1, 16'hFFFF, draw_gap(), p);
   endtask

   task automatic run_random(input int unsigned count, input bit with_gaps);
      slot_queue_response_type p;
      slot_ticket_type t;
      logic [MODE_W-1:0] m;
      logic [SLOT_W-1:0] idx;
      logic [GEN_W-1:0] tok;
      logic src;
      logic [LEN_W-1:0] len;
      int unsigned pick, k, n, done;
      done = 0;
      while (done < count) begin
         pick = $urandom_range(0, 99);
         idx  = SLOT_W'($urandom);
         tok  = GEN_W'($urandom);
         src  = 1'($urandom);
         len  = LEN_W'($urandom);
         n    = 1;
         if (pick < 2) begin
            // burst of reservations that runs into a full queue
            m = MODE_RESERVE_WRITE;
            n = QUEUE_CAPACITY_DEFAULT + 1;
         end else if (pick < 26) begin
            m   = MODE_RESERVE_WRITE;
            len = draw_length();
         end else if (pick < 48) begin
            m = MODE_COMMIT_WRITE;
            if (writing_tickets.size() != 0 && $urandom_range(0, 9) != 0) begin
               k   = $urandom_range(0, writing_tickets.size() - 1);
               t   = writing_tickets[k];
               idx = t.slot;
               tok = t.generation;
               if ($urandom_range(0, 7) == 0)
                  tok = tok ^ (GEN_W'(1) << $urandom_range(0, GEN_W - 1));
               else writing_tickets.delete(k);
            end
         end else if (pick < 70) begin
            m = MODE_RESERVE_READ;
         end else if (pick < 92) begin
            m = MODE_RELEASE_READ;
            if (reading_tickets.size() != 0 && $urandom_range(0, 9) != 0) begin
               k   = $urandom_range(0, reading_tickets.size() - 1);
               t   = reading_tickets[k];
               idx = t.slot;
               tok = t.generation;
               if ($urandom_range(0, 7) == 0)
                  tok = tok ^ (GEN_W'(1) << $urandom_range(0, GEN_W - 1));
               else reading_tickets.delete(k);
            end
         end else if (pick < 95) begin
            m = MODE_CLEAR;
         end else begin
            m = MODE_W'($urandom);
         end
         repeat (n) begin
            if (n > 1) len = LEN_W'($urandom_range(1, queue_model.max_len));
            issue(m, idx, tok, src, len, with_gaps ? draw_gap() : 0, p);
            keep_ticket(m, p);
         end
         done += n;
      end
   endtask

   initial begin
      queue_model = new();
      reset                <= 1'b1;
      start                <= 1'b0;
      csr_wr_en            <= 1'b0;
      csr_wr_data          <= '0;
      req_mode             <= '0;
      req_slot_index       <= '0;
      req_generation_token <= '0;
      req_source           <= 1'b0;
      req_payload_length   <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      run_random(350, 1'b1);
      program_max_length(16'd1);
      run_random(200, 1'b1);
      program_max_length(16'hFFFF);
      run_random(200, 1'b0);
      program_max_length(LEN_W'($urandom_range(2, 16'hFFFE)));
      run_random(200, 1'b1);
      run_random(400, 1'b1);
      program_max_length(MAX_LEN_RESET);
      run_random(250, 1'b1);

      wait_for_idle();
      repeat (3 + QUEUE_CAPACITY_DEFAULT + 5) @(posedge clock);
      if (!queue_model.failed())
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ----- two_phase_slot_command_queue.f -----
sv/tpsq_pkg.sv
sv/tpsq_ctrl.sv
sv/tpsq_datapath.sv
sv/two_phase_slot_command_queue.sv
bench/slot_queue_scoreboard_pkg.sv
bench/tb.sv
